FILE: hw/rtl/e2b_pkg.sv
// e2b_pkg: widths, angle constants and shared helpers for the Euler-angle to basis-vector block.
// No dependencies.
package e2b_pkg;
  localparam int unsigned OutWidth = 16;
  localparam int unsigned AngWidth = 20;
  localparam int unsigned ScDepth  = 9;
  localparam logic [16:0] AngFull  = 17'd92160;
  localparam logic [16:0] AngQuad  = 17'd23040;
  localparam logic [16:0] AngHalfq = 17'd11520;
  localparam logic [25:0] RadQ31   = 26'd37480660;
  localparam logic [32:0] QOne     = 33'h1_0000_0000 >> 1;

  // Reciprocals for exact floor division: 45 (>> 16), 42 and 56 (>> 37),
  // 20 and 30 (>> 36), 6 (>> 34), 12 (>> 35).
  localparam logic [10:0] Rcp45    = 11'd1457;
  localparam logic [31:0] Rcp42    = 32'd3272356036;
  localparam logic [31:0] Rcp56    = 32'd2454267027;
  localparam logic [31:0] Rcp20    = 32'd3435973837;
  localparam logic [31:0] Rcp30    = 32'd2290649225;
  localparam logic [31:0] Rcp6     = 32'd2863311531;
  localparam logic [31:0] Rcp12    = 32'd2863311531;

  typedef logic signed [AngWidth-1:0] ang_t;
  typedef logic signed [OutWidth-1:0] out_t;
  typedef logic signed [32:0] q31_t;

  typedef struct packed {
    ang_t pitch_deg;
    ang_t yaw_deg;
    ang_t roll_deg;
  } in_beat_t;

  typedef struct packed {
    out_t forward_x;
    out_t forward_y;
    out_t forward_z;
    out_t right_x;
    out_t right_y;
    out_t right_z;
    out_t up_x;
    out_t up_y;
    out_t up_z;
  } out_beat_t;

  // Q1.31 product, magnitudes rounded half away from zero.
  function automatic q31_t qmul(q31_t a, q31_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [32:0] r;
    ma = a[32] ? 32'(-a) : 32'(a);
    mb = b[32] ? 32'(-b) : 32'(b);
    p  = 64'(ma) * 64'(mb) + (64'd1 << 30);
    r  = p[63:31];
    return (a[32] ^ b[32]) ? q31_t'(-r) : q31_t'(r);
  endfunction

  // Q1.31 to Q1.(OutWidth-1), rounded on magnitude, saturated.
  function automatic out_t to_out(logic signed [34:0] v);
    localparam int unsigned Sh = 32 - OutWidth;
    localparam logic signed [35:0] Hi = (36'sd1 <<< (OutWidth - 1)) - 36'sd1;
    logic [34:0] mag;
    logic signed [35:0] r;
    mag = v[34] ? 35'(-v) : 35'(v);
    mag = (mag + ((35'd1 << Sh) >> 1)) >> Sh;
    r   = v[34] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (r > Hi) return out_t'(Hi);
    if (r < -Hi - 36'sd1) return out_t'(-Hi - 36'sd1);
    return out_t'(r);
  endfunction
endpackage

FILE: hw/rtl/e2b_stream_if.sv
// e2b_stream_if: valid/ready channel carrying a payload of type PayloadT.
// Depends on nothing; instantiated with e2b_pkg types.
interface e2b_stream_if #(parameter type PayloadT = logic);
  logic    valid;
  logic    ready;
  PayloadT data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/e2b_sincos.sv
// e2b_sincos: pipelined degree-angle sine/cosine in Q1.31 (polynomial, 9 stages).
// Depends on e2b_pkg. Stage enables come from the caller.
module e2b_sincos (
  input  logic                        clk_i,
  input  logic [e2b_pkg::ScDepth-1:0] en_i,
  input  e2b_pkg::ang_t               ang_i,
  output e2b_pkg::q31_t               sin_o,
  output e2b_pkg::q31_t               cos_o
);
  // stage 1: range reduce
  logic signed [8:0]  ah;
  logic [9:0]         hm;
  logic [3:0]         kq;
  logic [5:0]         k;
  logic [16:0]        m_d;
  logic [16:0]        n;
  logic [2:0]         qd;
  logic signed [18:0] r_d;
  logic signed [18:0] r1_q;
  logic [1:0]         q1_q;
  always_comb begin
    ah  = ang_i[19:11];
    hm  = {ah[8], ah} + 10'd270;
    kq  = 4'((20'(hm) * 20'(e2b_pkg::Rcp45)) >> 16);
    k   = 6'(hm - 10'(kq) * 10'd45);
    m_d = {k, ang_i[10:0]};
    n   = m_d + e2b_pkg::AngHalfq;
    qd  = 3'((19'(n[16:9]) * 19'(e2b_pkg::Rcp45)) >> 16);
    r_d = 19'($signed({2'b0, m_d}) - $signed({2'b0, 17'(17'(qd) * e2b_pkg::AngQuad)}));
  end
  always_ff @(posedge clk_i) if (en_i[0]) begin r1_q <= r_d; q1_q <= qd[1:0]; end

  // stage 2: radians
  logic [31:0] x2_q;
  logic [1:0]  q2_q;
  logic        n2_q;
  logic [13:0] ar;
  assign ar = r1_q[18] ? 14'(-r1_q) : 14'(r1_q);
  always_ff @(posedge clk_i) if (en_i[1]) begin
    x2_q <= 32'((40'(ar) * 40'(e2b_pkg::RadQ31)) >> 8);
    q2_q <= q1_q; n2_q <= r1_q[18];
  end

  // stage 3: x^2
  logic [31:0] x3_q, xx3_q;
  logic [1:0]  q3_q;
  logic        n3_q;
  always_ff @(posedge clk_i) if (en_i[2]) begin
    x3_q <= x2_q; q3_q <= q2_q; n3_q <= n2_q;
    xx3_q <= 32'((64'(x2_q) * 64'(x2_q)) >> 31);
  end

  // stage 4: first terms
  logic [31:0] x4_q, xx4_q, t4_q, u4_q;
  logic [1:0]  q4_q;
  logic        n4_q;
  always_ff @(posedge clk_i) if (en_i[3]) begin
    x4_q <= x3_q; xx4_q <= xx3_q; q4_q <= q3_q; n4_q <= n3_q;
    t4_q <= 32'(e2b_pkg::QOne) - 32'((64'(xx3_q) * 64'(e2b_pkg::Rcp42)) >> 37);
    u4_q <= 32'(e2b_pkg::QOne) - 32'((64'(xx3_q) * 64'(e2b_pkg::Rcp56)) >> 37);
  end

  // stage 5
  logic [31:0] x5_q, xx5_q, pt5_q, pu5_q;
  logic [1:0]  q5_q;
  logic        n5_q;
  always_ff @(posedge clk_i) if (en_i[4]) begin
    x5_q <= x4_q; xx5_q <= xx4_q; q5_q <= q4_q; n5_q <= n4_q;
    pt5_q <= 32'((64'(xx4_q) * 64'(t4_q)) >> 31);
    pu5_q <= 32'((64'(xx4_q) * 64'(u4_q)) >> 31);
  end

  // stage 6
  logic [31:0] x6_q, xx6_q, t6_q, u6_q;
  logic [1:0]  q6_q;
  logic        n6_q;
  always_ff @(posedge clk_i) if (en_i[5]) begin
    x6_q <= x5_q; xx6_q <= xx5_q; q6_q <= q5_q; n6_q <= n5_q;
    t6_q <= 32'(e2b_pkg::QOne) - 32'((64'(pt5_q) * 64'(e2b_pkg::Rcp20)) >> 36);
    u6_q <= 32'(e2b_pkg::QOne) - 32'((64'(pu5_q) * 64'(e2b_pkg::Rcp30)) >> 36);
  end

  // stage 7
  logic [31:0] x7_q, xx7_q, pt7_q, pu7_q;
  logic [1:0]  q7_q;
  logic        n7_q;
  always_ff @(posedge clk_i) if (en_i[6]) begin
    x7_q <= x6_q; xx7_q <= xx6_q; q7_q <= q6_q; n7_q <= n6_q;
    pt7_q <= 32'((64'(xx6_q) * 64'(t6_q)) >> 31);
    pu7_q <= 32'((64'(xx6_q) * 64'(u6_q)) >> 31);
  end

  // stage 8
  logic [31:0] x8_q, xx8_q, t8_q, u8_q;
  logic [1:0]  q8_q;
  logic        n8_q;
  always_ff @(posedge clk_i) if (en_i[7]) begin
    x8_q <= x7_q; xx8_q <= xx7_q; q8_q <= q7_q; n8_q <= n7_q;
    t8_q <= 32'(e2b_pkg::QOne) - 32'((64'(pt7_q) * 64'(e2b_pkg::Rcp6)) >> 34);
    u8_q <= 32'(e2b_pkg::QOne) - 32'((64'(pu7_q) * 64'(e2b_pkg::Rcp12)) >> 35);
  end

  // stage 9: finish and place by quadrant
  e2b_pkg::q31_t s, c;
  always_comb begin
    s = 33'((64'(x8_q) * 64'(t8_q)) >> 31);
    if (n8_q) s = -s;
    c = 33'(32'(e2b_pkg::QOne) - 32'(((64'(xx8_q) * 64'(u8_q)) >> 31) >> 1));
  end
  always_ff @(posedge clk_i) if (en_i[8]) begin
    case (q8_q)
      2'd0:    begin sin_o <= s;  cos_o <= c;  end
      2'd1:    begin sin_o <= c;  cos_o <= -s; end
      2'd2:    begin sin_o <= -s; cos_o <= -c; end
      default: begin sin_o <= -c; cos_o <= s;  end
    endcase
  end
endmodule

FILE: hw/rtl/euler_to_basis_vectors.sv
// euler_to_basis_vectors: top level, three sine/cosine pipes and the product stages.
// Depends on e2b_pkg, e2b_stream_if and e2b_sincos.
// One angle triple is taken every clock while in_i.ready is high; a result beat is offered
// once its input beat has passed twelve register stages: nine sine/cosine stages and three
// product and output conversion stages. Stages holding a beat stall when the output
// is not taken while empty stages keep filling, so no beat is lost or repeated.
module euler_to_basis_vectors (
  input  logic        clk_i,
  input  logic        rst_ni,
  e2b_stream_if.sink   in_i,
  e2b_stream_if.source out_o
);
  localparam int unsigned Depth = e2b_pkg::ScDepth + 3;
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] en;
  always_comb begin
    en[Depth-1] = !vld_q[Depth-1] || out_o.ready;
    for (int i = Depth - 2; i >= 0; i--) en[i] = !vld_q[i] || en[i+1];
  end
  assign in_i.ready = en[0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_i.valid;
      for (int i = 1; i < Depth; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  e2b_pkg::q31_t sp, cp, sy, cy, sr, cr;
  e2b_sincos u_p (.clk_i, .en_i(en[e2b_pkg::ScDepth-1:0]), .ang_i(in_i.data.pitch_deg),
                  .sin_o(sp), .cos_o(cp));
  e2b_sincos u_y (.clk_i, .en_i(en[e2b_pkg::ScDepth-1:0]), .ang_i(in_i.data.yaw_deg),
                  .sin_o(sy), .cos_o(cy));
  e2b_sincos u_r (.clk_i, .en_i(en[e2b_pkg::ScDepth-1:0]), .ang_i(in_i.data.roll_deg),
                  .sin_o(sr), .cos_o(cr));

  // stage 10: pair products
  e2b_pkg::q31_t srsp_q, crsp_q, cpcy_q, cpsy_q, crsy_q, crcy_q, sysr_q, srcy_q;
  e2b_pkg::q31_t srcp_q, crcp_q, sp7_q, cy7_q, sy7_q;
  always_ff @(posedge clk_i) if (en[e2b_pkg::ScDepth]) begin
    srsp_q <= e2b_pkg::qmul(sr, sp); crsp_q <= e2b_pkg::qmul(cr, sp);
    cpcy_q <= e2b_pkg::qmul(cp, cy); cpsy_q <= e2b_pkg::qmul(cp, sy);
    crsy_q <= e2b_pkg::qmul(cr, sy); crcy_q <= e2b_pkg::qmul(cr, cy);
    sysr_q <= e2b_pkg::qmul(sr, sy); srcy_q <= e2b_pkg::qmul(sr, cy);
    srcp_q <= e2b_pkg::qmul(sr, cp); crcp_q <= e2b_pkg::qmul(cr, cp);
    sp7_q <= sp; cy7_q <= cy; sy7_q <= sy;
  end

  // stage 11: triple products and sums
  logic signed [34:0] s8_q [9];
  always_ff @(posedge clk_i) if (en[e2b_pkg::ScDepth + 1]) begin
    s8_q[0] <= 35'(cpcy_q);
    s8_q[1] <= 35'(cpsy_q);
    s8_q[2] <= -35'(sp7_q);
    s8_q[3] <= -35'(e2b_pkg::qmul(srsp_q, cy7_q)) + 35'(crsy_q);
    s8_q[4] <= -35'(e2b_pkg::qmul(srsp_q, sy7_q)) - 35'(crcy_q);
    s8_q[5] <= -35'(srcp_q);
    s8_q[6] <= 35'(e2b_pkg::qmul(crsp_q, cy7_q)) + 35'(sysr_q);
    s8_q[7] <= 35'(e2b_pkg::qmul(crsp_q, sy7_q)) - 35'(srcy_q);
    s8_q[8] <= 35'(crcp_q);
  end

  // stage 12: output conversion
  e2b_pkg::out_beat_t ob_q;
  always_ff @(posedge clk_i) if (en[Depth-1]) begin
    ob_q.forward_x <= e2b_pkg::to_out(s8_q[0]);
    ob_q.forward_y <= e2b_pkg::to_out(s8_q[1]);
    ob_q.forward_z <= e2b_pkg::to_out(s8_q[2]);
    ob_q.right_x   <= e2b_pkg::to_out(s8_q[3]);
    ob_q.right_y   <= e2b_pkg::to_out(s8_q[4]);
    ob_q.right_z   <= e2b_pkg::to_out(s8_q[5]);
    ob_q.up_x      <= e2b_pkg::to_out(s8_q[6]);
    ob_q.up_y      <= e2b_pkg::to_out(s8_q[7]);
    ob_q.up_z      <= e2b_pkg::to_out(s8_q[8]);
  end
  assign out_o.valid = vld_q[Depth-1];
  assign out_o.data  = ob_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid) else $error("beat dropped");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready) else $error("stall without cause");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0]) else $error("beat lost at entry");
endmodule
